// ----- sv/hfm_pkg.sv -----
// Shared codes, field widths and the result record of the Huffman engine.
package hfm_pkg;
    localparam logic [2:0] CMD_CLEAR  = 3'd0;
    localparam logic [2:0] CMD_LOAD   = 3'd1;
    localparam logic [2:0] CMD_BUILD  = 3'd2;
    localparam logic [2:0] CMD_ENCODE = 3'd3;
    localparam logic [2:0] CMD_DECODE = 3'd4;
    localparam logic [2:0] CMD_END    = 3'd5;

    localparam logic [1:0] KIND_BUILD = 2'd0;
    localparam logic [1:0] KIND_CODE  = 2'd1;
    localparam logic [1:0] KIND_SYM   = 2'd2;
    localparam logic [1:0] KIND_END   = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_ABSENT    = 3'd1;
    localparam logic [2:0] ST_TOO_LONG  = 3'd2;
    localparam logic [2:0] ST_MID_CODE  = 3'd3;
    localparam logic [2:0] ST_TOO_SMALL = 3'd4;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 56;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  out_symbol;
        logic [31:0] code_value;
        logic [5:0]  code_length;
        logic [2:0]  status;
    } t_result;
endpackage

// ----- sv/hfm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module hfm_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- sv/huffman_tree_build_encode_decode_unit.sv -----
// Huffman engine top level: leaf table, tree build, encode and decode sequencer.
//
// Usage: requests enter on the slave stream (i_s_*), cmd in tuser, the
// symbol, weight and code bit in tdata. Results leave on the master stream
// (o_m_*), kind in tuser. Clear and load give no result; build, encode and
// end always give one; decode gives one when a leaf is reached.
// Encode searches the leaf table in order for the symbol. Build (n =
// leaves loaded) runs a clearing pass over the parent flags of the leaves,
// then n-1 merges, each a scan of the node table through the weight RAM
// read port followed by the write states MG0, MG1 and MG2, then a code
// walk from every leaf up to the root. One shared compare unit does the
// minimum search; the node RAMs each have one read and one write port.
// o_s_tready is high only while the sequencer is idle. A result waits in
// the output register while the receiver stalls; the next request is still
// taken, and the sequencer holds in its response state until the register
// is free. Reset empties the leaf table, drops the tree and the result;
// RAM contents are not cleared.
module huffman_tree_build_encode_decode_unit #(
    parameter int MAX_SYMBOLS  = 256,
    parameter int MAX_CODE_LEN = 32,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    // [7:0] symbol, [23:8] weight, [24] code_bit, rest zero
    input  logic [hfm_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // [2:0] cmd
    input  logic [2:0]                   i_s_tuser,
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    // [7:0] out_symbol, [39:8] code_value, [45:40] code_length, [48:46] status
    output logic [hfm_pkg::OUT_DATA_W-1:0] o_m_tdata,
    // [1:0] kind
    output logic [1:0]                   o_m_tuser
);
    import hfm_pkg::*;

    localparam int NODE_MAX = 2 * MAX_SYMBOLS - 1;
    localparam int NB       = $clog2(NODE_MAX);
    localparam int LB       = $clog2(MAX_SYMBOLS);
    localparam int CB       = $clog2(MAX_SYMBOLS + 1);
    localparam int WW       = WEIGHT_BITS + $clog2(MAX_SYMBOLS);
    localparam int LIMIT    = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;
    localparam int LCW      = 39;
    localparam logic [15:0] WMASK = (WEIGHT_BITS >= 16) ? 16'hFFFF
                                  : 16'((1 << WEIGHT_BITS) - 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_HPCLR = 4'd1;
    localparam logic [3:0] S_SCAN  = 4'd2;
    localparam logic [3:0] S_MG0   = 4'd3;
    localparam logic [3:0] S_MG1   = 4'd4;
    localparam logic [3:0] S_MG2   = 4'd5;
    localparam logic [3:0] S_CWA   = 4'd6;
    localparam logic [3:0] S_CWB   = 4'd7;
    localparam logic [3:0] S_CWC   = 4'd8;
    localparam logic [3:0] S_CWD   = 4'd9;
    localparam logic [3:0] S_ENCA  = 4'd10;
    localparam logic [3:0] S_ENCB  = 4'd11;
    localparam logic [3:0] S_DEC0  = 4'd12;
    localparam logic [3:0] S_DEC1  = 4'd13;
    localparam logic [3:0] S_DEC2  = 4'd14;
    localparam logic [3:0] S_RESP  = 4'd15;

    // result record with the code fields cleared
    function automatic t_result res_of(logic [1:0] kind, logic [7:0] sym,
                                       logic [2:0] st);
        t_result r;
        r = '0;
        r.kind       = kind;
        r.out_symbol = sym;
        r.status     = st;
        return r;
    endfunction

    // request fields
    logic          accept;
    logic [2:0]    in_cmd;
    logic [7:0]    in_sym;
    logic [WW-1:0] in_wgt;
    logic          in_bit;

    assign accept = i_s_tvalid && o_s_tready;
    assign in_cmd = i_s_tuser;
    assign in_sym = i_s_tdata[7:0];
    assign in_wgt = WW'(i_s_tdata[23:8] & WMASK);
    assign in_bit = i_s_tdata[24];

    // control and datapath registers
    logic [3:0]    r_state;
    logic [CB-1:0] r_n;
    logic          r_tv;
    logic [NB-1:0] r_dn;
    logic [7:0]    r_sym;
    logic          r_bit;
    logic [NB-1:0] r_j, r_t, r_pj, r_a, r_b, r_node, r_p, r_i, r_cur;
    logic          r_pv, r_fa, r_fb;
    logic [WW-1:0] r_wa, r_wb;
    logic [31:0]   r_code;
    logic [8:0]    r_len;
    t_result       r_res, r_out;
    logic          r_ov;

    // RAM ports
    logic          w_we, hp_we, par_we, lft_we, rgt_we, sym_we, lc_we;
    logic [NB-1:0] w_waddr, hp_waddr, par_waddr, lft_waddr, rgt_waddr;
    logic [NB-1:0] w_raddr, hp_raddr, par_raddr, lft_raddr, rgt_raddr;
    logic [LB-1:0] sym_waddr, sym_raddr, lc_waddr, lc_raddr;
    logic [WW-1:0] w_wdata, w_q;
    logic          hp_wdata, hp_q;
    logic [NB-1:0] par_wdata, par_q, lft_wdata, lft_q, rgt_wdata, rgt_q;
    logic [7:0]    sym_wdata, sym_q;
    logic [LCW-1:0] lc_wdata, lc_q;

    logic [NB-1:0] n_nb, root_idx, dec_next;
    logic          can_load, too_long;

    assign n_nb     = NB'(r_n);
    assign root_idx = NB'(({1'b0, r_n} << 1) - (CB + 1)'(2));
    assign dec_next = r_bit ? rgt_q : lft_q;
    assign can_load = r_n < CB'(MAX_SYMBOLS);
    assign too_long = r_len > 9'(LIMIT);

    always_comb begin
        w_we = 1'b0;  w_waddr = NB'(r_n); w_wdata = in_wgt;
        hp_we = 1'b0; hp_waddr = r_j;     hp_wdata = 1'b0;
        par_we = 1'b0; par_waddr = r_a;   par_wdata = r_t;
        lft_we = 1'b0; lft_waddr = r_t;   lft_wdata = r_a;
        rgt_we = 1'b0; rgt_waddr = r_t;   rgt_wdata = r_b;
        sym_we = 1'b0; sym_waddr = r_n[LB-1:0]; sym_wdata = in_sym;
        lc_we = 1'b0;  lc_waddr = r_i[LB-1:0];
        lc_wdata = too_long ? {1'b1, 38'd0} : {1'b0, 6'(r_len), r_code};
        w_raddr   = r_j;
        hp_raddr  = (r_state == S_SCAN) ? r_j : r_node;
        par_raddr = r_node;
        lft_raddr = (r_state == S_CWC || r_state == S_CWD) ? r_p : r_cur;
        rgt_raddr = r_cur;
        sym_raddr = (r_state == S_DEC1) ? dec_next[LB-1:0] : r_j[LB-1:0];
        lc_raddr  = r_j[LB-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (accept && in_cmd == CMD_LOAD && can_load) begin
                    w_we   = 1'b1;
                    sym_we = 1'b1;
                end
            end
            S_HPCLR: hp_we = 1'b1;
            S_MG0: begin
                w_we = 1'b1; w_waddr = r_t; w_wdata = r_wa + r_wb;
                hp_we = 1'b1; hp_waddr = r_a; hp_wdata = 1'b1;
                par_we = 1'b1;
                lft_we = 1'b1;
                rgt_we = 1'b1;
            end
            S_MG1: begin
                hp_we = 1'b1; hp_waddr = r_b; hp_wdata = 1'b1;
                par_we = 1'b1; par_waddr = r_b;
            end
            S_MG2: begin
                hp_we = 1'b1; hp_waddr = r_t; hp_wdata = 1'b0;
            end
            S_CWB: lc_we = !hp_q;
            default: ;
        endcase
    end

    hfm_ram #(.W(WW), .D(NODE_MAX)) u_w_ram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_q));
    hfm_ram #(.W(1), .D(NODE_MAX)) u_hp_ram (
        .i_clk(i_clk), .i_we(hp_we), .i_waddr(hp_waddr), .i_wdata(hp_wdata),
        .i_raddr(hp_raddr), .o_rdata(hp_q));
    hfm_ram #(.W(NB), .D(NODE_MAX)) u_par_ram (
        .i_clk(i_clk), .i_we(par_we), .i_waddr(par_waddr), .i_wdata(par_wdata),
        .i_raddr(par_raddr), .o_rdata(par_q));
    hfm_ram #(.W(NB), .D(NODE_MAX)) u_lft_ram (
        .i_clk(i_clk), .i_we(lft_we), .i_waddr(lft_waddr), .i_wdata(lft_wdata),
        .i_raddr(lft_raddr), .o_rdata(lft_q));
    hfm_ram #(.W(NB), .D(NODE_MAX)) u_rgt_ram (
        .i_clk(i_clk), .i_we(rgt_we), .i_waddr(rgt_waddr), .i_wdata(rgt_wdata),
        .i_raddr(rgt_raddr), .o_rdata(rgt_q));
    hfm_ram #(.W(8), .D(MAX_SYMBOLS)) u_sym_ram (
        .i_clk(i_clk), .i_we(sym_we), .i_waddr(sym_waddr), .i_wdata(sym_wdata),
        .i_raddr(sym_raddr), .o_rdata(sym_q));
    hfm_ram #(.W(LCW), .D(MAX_SYMBOLS)) u_lc_ram (
        .i_clk(i_clk), .i_we(lc_we), .i_waddr(lc_waddr), .i_wdata(lc_wdata),
        .i_raddr(lc_raddr), .o_rdata(lc_q));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_n     <= '0;
            r_tv    <= 1'b0;
            r_dn    <= '0;
            r_ov    <= 1'b0;
            r_pv    <= 1'b0;
        end else begin
            // output register: filled from the response state, emptied on handshake
            if (r_state == S_RESP && (!r_ov || i_m_tready)) begin
                r_ov <= 1'b1;
            end else if (r_ov && i_m_tready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        unique case (in_cmd)
                            CMD_CLEAR: begin
                                r_n  <= '0;
                                r_dn <= '0;
                                r_tv <= 1'b0;
                            end
                            CMD_LOAD: begin
                                if (can_load) begin
                                    r_n <= r_n + CB'(1);
                                end
                                r_tv <= 1'b0;
                                r_dn <= '0;
                            end
                            CMD_BUILD: begin
                                if (r_n < CB'(2)) begin
                                    r_tv <= 1'b0;
                                    r_dn <= '0;
                                    r_res <= res_of(KIND_BUILD, 8'd0, ST_TOO_SMALL);
                                    r_state <= S_RESP;
                                end else begin
                                    r_j     <= '0;
                                    r_state <= S_HPCLR;
                                end
                            end
                            CMD_ENCODE: begin
                                if (!r_tv) begin
                                    r_res <= res_of(KIND_CODE, 8'd0, ST_ABSENT);
                                    r_state <= S_RESP;
                                end else begin
                                    r_res   <= res_of(KIND_CODE, 8'd0, ST_OK);
                                    r_j     <= '0;
                                    r_sym   <= in_sym;
                                    r_state <= S_ENCA;
                                end
                            end
                            CMD_DECODE: begin
                                if (r_tv) begin
                                    // stale position falls back to the root
                                    r_cur <= (r_dn < n_nb || r_dn > root_idx) ? root_idx
                                                                              : r_dn;
                                    r_bit   <= in_bit;
                                    r_state <= S_DEC0;
                                end
                            end
                            CMD_END: begin
                                if (!r_tv) begin
                                    r_res <= res_of(KIND_END, 8'd0, ST_TOO_SMALL);
                                end else begin
                                    r_res <= res_of(KIND_END, 8'd0,
                                                    (r_dn == root_idx) ? ST_OK : ST_MID_CODE);
                                    r_dn <= root_idx;
                                end
                                r_state <= S_RESP;
                            end
                            default: ;
                        endcase
                    end
                end
                S_HPCLR: begin
                    if (r_j == n_nb - NB'(1)) begin
                        r_t  <= n_nb;
                        r_j  <= '0;
                        r_pv <= 1'b0;
                        r_fa <= 1'b0;
                        r_fb <= 1'b0;
                        r_state <= S_SCAN;
                    end else begin
                        r_j <= r_j + NB'(1);
                    end
                end
                S_SCAN: begin
                    // two-smallest search, lowest index wins ties
                    if (r_pv && !hp_q) begin
                        if (!r_fa || w_q < r_wa) begin
                            r_b <= r_a; r_wb <= r_wa; r_fb <= r_fa;
                            r_a <= r_pj; r_wa <= w_q; r_fa <= 1'b1;
                        end else if (!r_fb || w_q < r_wb) begin
                            r_b <= r_pj; r_wb <= w_q; r_fb <= 1'b1;
                        end
                    end
                    if (r_j < r_t) begin
                        r_pv <= 1'b1;
                        r_pj <= r_j;
                        r_j  <= r_j + NB'(1);
                    end else begin
                        r_pv <= 1'b0;
                        if (!r_pv) begin
                            r_state <= S_MG0;
                        end
                    end
                end
                S_MG0: r_state <= S_MG1;
                S_MG1: r_state <= S_MG2;
                S_MG2: begin
                    if (r_t == root_idx) begin
                        r_i    <= '0;
                        r_node <= '0;
                        r_code <= '0;
                        r_len  <= '0;
                        r_state <= S_CWA;
                    end else begin
                        r_t  <= r_t + NB'(1);
                        r_j  <= '0;
                        r_pv <= 1'b0;
                        r_fa <= 1'b0;
                        r_fb <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_CWA: r_state <= S_CWB;
                S_CWB: begin
                    if (!hp_q) begin
                        // reached the root: code stored this cycle
                        if (r_i == n_nb - NB'(1)) begin
                            r_dn <= root_idx;
                            r_tv <= 1'b1;
                            r_res <= res_of(KIND_BUILD, 8'd0, ST_OK);
                            r_state <= S_RESP;
                        end else begin
                            r_i    <= r_i + NB'(1);
                            r_node <= r_i + NB'(1);
                            r_code <= '0;
                            r_len  <= '0;
                            r_state <= S_CWA;
                        end
                    end else begin
                        r_p <= par_q;
                        r_state <= S_CWC;
                    end
                end
                S_CWC: r_state <= S_CWD;
                S_CWD: begin
                    if (r_len < 9'(LIMIT)) begin
                        r_code[r_len[4:0]] <= (lft_q != r_node);
                    end
                    r_len  <= r_len + 9'd1;
                    r_node <= r_p;
                    r_state <= S_CWA;
                end
                S_ENCA: r_state <= S_ENCB;
                S_ENCB: begin
                    if (sym_q == r_sym) begin
                        if (lc_q[38]) begin
                            r_res.status <= ST_TOO_LONG;
                        end else begin
                            r_res.code_length <= lc_q[37:32];
                            r_res.code_value  <= lc_q[31:0];
                        end
                        r_state <= S_RESP;
                    end else if (r_j == n_nb - NB'(1)) begin
                        r_res.status <= ST_ABSENT;
                        r_state <= S_RESP;
                    end else begin
                        r_j <= r_j + NB'(1);
                        r_state <= S_ENCA;
                    end
                end
                S_DEC0: r_state <= S_DEC1;
                S_DEC1: begin
                    if (dec_next < n_nb) begin
                        r_state <= S_DEC2;
                    end else begin
                        r_dn <= dec_next;
                        r_state <= S_IDLE;
                    end
                end
                S_DEC2: begin
                    r_res <= res_of(KIND_SYM, sym_q, ST_OK);
                    r_dn <= root_idx;
                    r_state <= S_RESP;
                end
                S_RESP: begin
                    if (!r_ov || i_m_tready) begin
                        r_out <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ov;
    assign o_m_tuser  = r_out.kind;
    assign o_m_tdata  = {7'd0, r_out.status, r_out.code_length, r_out.code_value,
                         r_out.out_symbol};
endmodule

// ----- sv/hfm_chk.sv -----
// Port-level checker for the Huffman engine, bound to the top level.
module hfm_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [31:0] i_s_tdata,
    input logic [2:0]  i_s_tuser,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [55:0] o_m_tdata,
    input logic [1:0]  o_m_tuser
);
    import hfm_pkg::*;

    a_reset_drops_result: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

    a_build_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tuser == CMD_BUILD |=> !o_s_tready)
        else $error("ready right after build request");

    a_code_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == KIND_CODE && o_m_tdata[48:46] != ST_OK
        |-> o_m_tdata[45:8] == 38'd0)
        else $error("failed encode carries code bits");
endmodule

bind huffman_tree_build_encode_decode_unit hfm_chk u_hfm_chk (.*);

// ----- bench/tb_huffman_tree_build_encode_decode_unit.sv -----
// Stream-level self-checking bench for the Huffman build/encode/decode engine.
module tb_huffman_tree_build_encode_decode_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import hfm_pkg::*;

    localparam int LEAVES_MAX = 256;
    localparam int NODES_MAX  = 2 * LEAVES_MAX - 1;
    localparam int CODE_CAP   = 32;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  symbol;
        logic [15:0] weight;
        logic        code_bit;
    } t_request;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // [7:0] symbol, [23:8] weight, [24] code_bit
    logic [2:0]  s_tuser = '0;   // [2:0] cmd
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;        // [7:0] symbol, [39:8] code, [45:40] length, [48:46] status
    logic [1:0]  m_tuser;        // [1:0] kind

    huffman_tree_build_encode_decode_unit uut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .o_m_tdata(m_tdata), .o_m_tuser(m_tuser)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // predictor state
    logic [31:0] nd_weight [NODES_MAX];
    int          nd_parent [NODES_MAX];
    int          nd_left   [NODES_MAX];
    int          nd_right  [NODES_MAX];
    bit          nd_linked [NODES_MAX];
    logic [7:0]  lf_symbol [LEAVES_MAX];
    logic [31:0] lf_code   [LEAVES_MAX];
    logic [5:0]  lf_len    [LEAVES_MAX];
    bit          lf_long   [LEAVES_MAX];
    int          lf_count = 0;
    int          walk_node = 0;
    bit          tree_ok = 0;

    t_request request_q[$];
    t_result  answer_q[$];
    int       mismatches = 0;
    int       send_idle_pct = 17, recv_idle_pct = 76;
    bit       recv_hold = 0, send_pause = 0;

    function automatic t_result mk(logic [1:0] k, logic [7:0] s, logic [31:0] v,
                                   logic [5:0] l, logic [2:0] st);
        t_result r;
        r.kind = k; r.out_symbol = s; r.code_value = v; r.code_length = l; r.status = st;
        return r;
    endfunction

    task automatic grow_tree(int n);
        int t, a, b, node, len, guard, p;
        logic [31:0] wa, wb, code;
        bit fa, fb;
        for (int j = 0; j < n; j++) nd_linked[j] = 0;
        for (int i = 0; i + 1 < n; i++) begin
            t = n + i; a = 0; b = 0; wa = 0; wb = 0; fa = 0; fb = 0;
            for (int j = 0; j < t; j++) begin
                if (nd_linked[j]) continue;
                if (!fa || nd_weight[j] < wa) begin
                    b = a; wb = wa; fb = fa;
                    a = j; wa = nd_weight[j]; fa = 1;
                end else if (!fb || nd_weight[j] < wb) begin
                    b = j; wb = nd_weight[j]; fb = 1;
                end
            end
            nd_parent[a] = t; nd_parent[b] = t;
            nd_linked[a] = 1; nd_linked[b] = 1;
            nd_weight[t] = wa + wb;
            nd_left[t] = a; nd_right[t] = b; nd_linked[t] = 0;
        end
        for (int i = 0; i < n; i++) begin
            node = i; len = 0; guard = 0; code = 0;
            while (nd_linked[node] && guard < NODES_MAX) begin
                p = nd_parent[node];
                if (len < CODE_CAP && nd_left[p] != node) code[len] = 1'b1;
                len++; node = p; guard++;
            end
            lf_long[i] = len > CODE_CAP;
            lf_code[i] = lf_long[i] ? 32'd0 : code;
            lf_len[i]  = lf_long[i] ? 6'd0 : 6'(len);
        end
        walk_node = 2 * n - 2;
        tree_ok = 1;
    endtask

    // apply one accepted request to the predictor
    task automatic predict_request(t_request rq);
        int n, root, cur, nxt;
        bit found;
        n = lf_count; root = 2 * n - 2; found = 0;
        case (rq.cmd)
            CMD_CLEAR: begin
                lf_count = 0; walk_node = 0; tree_ok = 0;
            end
            CMD_LOAD: begin
                if (lf_count < LEAVES_MAX) begin
                    lf_symbol[lf_count] = rq.symbol;
                    nd_weight[lf_count] = rq.weight;
                    lf_count++;
                end
                tree_ok = 0; walk_node = 0;
            end
            CMD_BUILD: begin
                if (n < 2) begin
                    tree_ok = 0; walk_node = 0;
                    answer_q.push_back(mk(KIND_BUILD, 0, 0, 0, ST_TOO_SMALL));
                end else begin
                    grow_tree(n);
                    answer_q.push_back(mk(KIND_BUILD, 0, 0, 0, ST_OK));
                end
            end
            CMD_ENCODE: begin
                if (tree_ok)
                    for (int j = 0; j < n && !found; j++)
                        if (lf_symbol[j] == rq.symbol) begin
                            found = 1;
                            if (lf_long[j]) answer_q.push_back(mk(KIND_CODE, 0, 0, 0, ST_TOO_LONG));
                            else answer_q.push_back(mk(KIND_CODE, 0, lf_code[j], lf_len[j], ST_OK));
                        end
                if (!found) answer_q.push_back(mk(KIND_CODE, 0, 0, 0, ST_ABSENT));
            end
            CMD_DECODE: begin
                if (tree_ok) begin
                    cur = walk_node;
                    if (cur < n || cur > root) cur = root;
                    nxt = rq.code_bit ? nd_right[cur] : nd_left[cur];
                    if (nxt < n) begin
                        walk_node = root;
                        answer_q.push_back(mk(KIND_SYM, lf_symbol[nxt], 0, 0, ST_OK));
                    end else walk_node = nxt;
                end
            end
            CMD_END: begin
                if (!tree_ok) answer_q.push_back(mk(KIND_END, 0, 0, 0, ST_TOO_SMALL));
                else begin
                    answer_q.push_back(mk(KIND_END, 0, 0, 0,
                                          walk_node == root ? ST_OK : ST_MID_CODE));
                    walk_node = root;
                end
            end
            default: ;
        endcase
    endtask

    // driver: one request in flight on the slave stream
    always @(posedge clk) begin
        if (rst_n) begin
            if (s_tvalid && s_tready) predict_request({s_tuser, s_tdata[7:0],
                                                      s_tdata[23:8], s_tdata[24]});
            if (!s_tvalid || s_tready) begin
                if (request_q.size() > 0 && !send_pause &&
                    $urandom_range(99) >= send_idle_pct) begin
                    t_request rq;
                    rq = request_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= rq.cmd;
                    s_tdata  <= {7'd0, rq.code_bit, rq.weight, rq.symbol};
                end else s_tvalid <= 1'b0;
            end
        end
    end

    // monitor: receiver stall and field compare
    always @(posedge clk) begin
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                t_result got, exp_r;
                got = mk(m_tuser, m_tdata[7:0], m_tdata[39:8], m_tdata[45:40], m_tdata[48:46]);
                if (answer_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %p", got);
                end else begin
                    exp_r = answer_q.pop_front();
                    if (got !== exp_r) begin
                        mismatches++;
                        if (mismatches <= 10) $display("mismatch exp %p got %p", exp_r, got);
                    end
                end
            end
            m_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic add(logic [2:0] c, logic [7:0] s = 0, logic [15:0] w = 0, logic b = 0);
        t_request rq;
        rq.cmd = c; rq.symbol = s; rq.weight = w; rq.code_bit = b;
        request_q.push_back(rq);
    endtask

    task automatic drain();
        while (request_q.size() > 0 || s_tvalid) @(posedge clk);
        while (answer_q.size() > 0) @(posedge clk);
    endtask

    // random frame: load a table, build, then mostly well-formed traffic
    task automatic random_frame(int nleaf);
        int bits;
        add(CMD_CLEAR);
        for (int i = 0; i < nleaf; i++)
            add(CMD_LOAD, 8'($urandom_range(255)),
                ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(20)));
        add(CMD_BUILD);
        bits = $urandom_range(30, 5);
        for (int i = 0; i < bits; i++) begin
            case ($urandom_range(9))
                0, 1: add(CMD_ENCODE, 8'($urandom_range(255)));
                2: add(CMD_END);
                3: add(3'($urandom_range(7)), 8'($urandom), 16'($urandom), 1'($urandom));
                default: add(CMD_DECODE, 0, 0, 1'($urandom_range(1)));
            endcase
        end
        add(CMD_END);
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        // directed: empty tree, too small, extremes, deep chain, ignored codes
        add(CMD_ENCODE, 8'h00); add(CMD_DECODE, 0, 0, 1); add(CMD_END); add(CMD_BUILD);
        add(CMD_LOAD, 8'hFF, 16'hFFFF); add(CMD_BUILD);
        add(CMD_LOAD, 8'h00, 16'h0000); add(CMD_LOAD, 8'hFF, 16'hFFFF);
        add(CMD_BUILD); add(CMD_ENCODE, 8'hFF); add(CMD_ENCODE, 8'h00);
        add(CMD_DECODE, 0, 0, 0); add(CMD_DECODE, 0, 0, 1); add(CMD_END);
        add(3'd6, 8'hAA, 16'h5555, 1); add(3'd7, 8'h55, 16'hAAAA, 0);
        add(CMD_ENCODE, 8'h12); add(CMD_CLEAR); add(CMD_ENCODE, 8'h00);
        // Fibonacci weights: a deep, lopsided tree with long codes
        begin
            int fa, fb, ft;
            fa = 1; fb = 1;
            add(CMD_CLEAR);
            for (int i = 0; i < 36; i++) begin
                add(CMD_LOAD, 8'(i), 16'(i < 22 ? fa : 16'hFFFF));
                ft = fa + fb; fa = fb; fb = ft;
            end
            add(CMD_BUILD); add(CMD_ENCODE, 8'd0); add(CMD_ENCODE, 8'd35);
            add(CMD_DECODE, 0, 0, 0); add(CMD_DECODE, 0, 0, 1); add(CMD_END);
        end
        // full table plus one ignored load, duplicates included
        add(CMD_CLEAR);
        for (int i = 0; i < 257; i++) add(CMD_LOAD, 8'(i % 200), 16'($urandom_range(3)));
        add(CMD_BUILD); add(CMD_ENCODE, 8'd5); add(CMD_ENCODE, 8'd250); add(CMD_END);
        drain();

        // sender pause mid-frame: hold off until all results are in
        random_frame(5);
        while (request_q.size() > 10) @(posedge clk);
        send_pause = 1;
        while (s_tvalid || answer_q.size() > 0) @(posedge clk);
        send_pause = 0;
        drain();

        // long receiver hold while the sender keeps offering
        random_frame(6);
        recv_hold = 1;
        repeat (400) @(posedge clk);
        recv_hold = 0;
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 76 : 0;
            recv_idle_pct = (phase == 0) ? 76 : (phase == 1) ? 17 : 0;
            for (int f = 0; f < 6; f++)
                random_frame(($urandom_range(9) == 0) ? $urandom_range(60, 2)
                                                     : $urandom_range(12, 1));
            drain();
        end
        repeat (50) @(posedge clk);
        if (mismatches == 0 && answer_q.size() == 0)
            $display("tb_huffman_tree_build_encode_decode_unit: done, clean");
        else
            $display("tb_huffman_tree_build_encode_decode_unit: done, errors");
        $finish;
    end

    initial begin
        #20ms;
        $display("tb_huffman_tree_build_encode_decode_unit: done, errors");
        $finish;
    end
endmodule
